/* sv/baro_temp_pressure_compensation_assert.svh */
// Assertion macros for the barometric compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
// implication checked on every clock edge out of reset
`define BTPC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define BTPC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* sv/btpc_pkg.sv */
// ---------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric compensation block.
// ---------------------------------------------------------------------------
`default_nettype none
package btpc_pkg;
  localparam int unsigned CfgAc12 = 0;
  localparam int unsigned CfgAc34 = 1;
  localparam int unsigned CfgAc56 = 2;
  localparam int unsigned CfgB12  = 3;
  localparam int unsigned CfgMcMd = 4;
  localparam int unsigned CfgOss  = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [31:0] RstAc12 = 32'd26804152;
  localparam logic [31:0] RstAc34 = 32'd3352395749;
  localparam logic [31:0] RstAc56 = 32'd2146785905;
  localparam logic [31:0] RstB12  = 32'd405667844;
  localparam logic [31:0] RstMcMd = 32'd3724086068;

  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
  } item_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] p;
    logic [15:0] tens;
    logic        fault;
  } result_t;

  typedef struct packed {
    logic [31:0] ac12;
    logic [31:0] ac34;
    logic [31:0] ac56;
    logic [31:0] b12;
    logic [31:0] mcmd;
    logic [1:0]  oss;
  } coef_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] v, input logic [4:0] s);
    sra = 32'($signed(v) >>> s);
  endfunction
endpackage
`default_nettype wire

/* sv/btpc_div.sv */
// ---------------------------------------------------------------------------
// btpc_div
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q_r, q_nxt, rem_r, rem_nxt, d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r, q_r[31]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0]; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end

  assign done     = busy_r && (cnt_r == 6'd1);
  assign quotient = trial[32] ? {q_r[30:0], 1'b0} : {q_r[30:0], 1'b1};
endmodule
`default_nettype wire

/* sv/btpc_front.sv */
// ---------------------------------------------------------------------------
// btpc_front
// Input side: accepts raw readings into a short queue.
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire btpc_pkg::item_t in_item,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output btpc_pkg::item_t      q_item
);
  import btpc_pkg::*;
  item_t      mem_r [QDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = cnt_r != 2'(QDepth);
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

/* sv/btpc_back.sv */
// ---------------------------------------------------------------------------
// btpc_back
// Compensation sequencer: at most one shared-multiplier product per step, shared serial divider.
// ---------------------------------------------------------------------------
`default_nettype none
module btpc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire btpc_pkg::coef_t   coef,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire btpc_pkg::item_t   q_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output btpc_pkg::result_t      res
);
  import btpc_pkg::*;
  localparam logic [4:0] S_IDLE = 5'd0,  S_X1T = 5'd1,  S_TDIV = 5'd2,  S_TW = 5'd3,
                         S_B6 = 5'd4,    S_SQ = 5'd5,   S_M1 = 5'd6,    S_M2 = 5'd7,
                         S_M3 = 5'd8,    S_M4 = 5'd9,   S_B3 = 5'd10,   S_B4 = 5'd11,
                         S_B7 = 5'd12,   S_PDIV = 5'd13, S_PW = 5'd14,  S_P1 = 5'd15,
                         S_P2 = 5'd16,   S_P3 = 5'd17,  S_P4 = 5'd18,   S_TEN = 5'd19,
                         S_OUT = 5'd20;
  logic [4:0]  st_r, st_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, e_r, b5_r, sq_r, x_r;
  logic [15:0] ut_r;
  logic [18:0] up_r;
  logic [31:0] mul_a, mul_b, prod;
  logic        dstart, ddone;
  logic [31:0] dnd, dsr, dq;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [1:0]  oss;
  logic        neg_r;
  logic [31:0] tq, mag, den;

  assign ac1 = sx16(coef.ac12[31:16]); assign ac2 = sx16(coef.ac12[15:0]);
  assign ac3 = sx16(coef.ac34[31:16]); assign ac4 = {16'd0, coef.ac34[15:0]};
  assign ac5 = {16'd0, coef.ac56[31:16]}; assign ac6 = {16'd0, coef.ac56[15:0]};
  assign b1  = sx16(coef.b12[31:16]);  assign b2  = sx16(coef.b12[15:0]);
  assign mc  = sx16(coef.mcmd[31:16]); assign md  = sx16(coef.mcmd[15:0]);
  assign oss = coef.oss;
  assign prod = mul_a * mul_b;
  assign den  = a_r + md;

  btpc_div u_div (.clk, .rst_n, .start(dstart), .dividend(dnd), .divisor(dsr),
                  .done(ddone), .quotient(dq));

  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign res_valid = st_r == S_OUT;

  // sign-magnitude handling for the signed temperature division
  assign mag = mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
  assign tq  = neg_r ? (~dq + 32'd1) : dq;

  always_comb begin
    st_nxt = st_r; mul_a = '0; mul_b = '0;
    dstart = 1'b0; dnd = '0; dsr = '0;
    unique case (st_r)
      S_IDLE:  if (q_valid) st_nxt = S_X1T;
      S_X1T:   begin mul_a = {16'd0, ut_r} - ac6; mul_b = ac5; st_nxt = S_TDIV; end
      S_TDIV:  begin
        if (a_r + md == 32'd0) st_nxt = S_OUT;
        else begin
          dstart = 1'b1; dnd = mag; st_nxt = S_TW;
          dsr = a_r + md;
          dsr = dsr[31] ? (~dsr + 32'd1) : dsr;
        end
      end
      S_TW:    if (ddone) st_nxt = S_B6;
      S_B6:    begin mul_a = b5_r - 32'd4000; mul_b = b5_r - 32'd4000; st_nxt = S_SQ; end
      S_SQ:    begin mul_a = b2; mul_b = sq_r; st_nxt = S_M1; end
      S_M1:    begin mul_a = ac2; mul_b = e_r; st_nxt = S_M2; end
      S_M2:    begin mul_a = ac3; mul_b = e_r; st_nxt = S_M3; end
      S_M3:    begin mul_a = b1; mul_b = sq_r; st_nxt = S_M4; end
      S_M4:    st_nxt = S_B3;
      S_B3:    begin mul_a = ac4; mul_b = c_r + 32'd32768; st_nxt = S_B4; end
      S_B4:    begin
        mul_a = {13'd0, up_r} - a_r; mul_b = 32'd50000 >> oss;
        st_nxt = (b_r == 32'd0) ? S_OUT : S_B7;
      end
      S_B7:    begin
        dstart = 1'b1; dsr = b_r;
        dnd = c_r[31] ? c_r : {c_r[30:0], 1'b0};
        st_nxt = S_PDIV;
      end
      S_PDIV:  st_nxt = S_PW;
      S_PW:    if (ddone) st_nxt = S_P1;
      S_P1:    begin mul_a = sra(x_r, 5'd8); mul_b = sra(x_r, 5'd8); st_nxt = S_P2; end
      S_P2:    begin mul_a = a_r; mul_b = 32'd3038; st_nxt = S_P3; end
      S_P3:    begin mul_a = 32'd7357; mul_b = x_r; st_nxt = S_P4; end
      S_P4:    st_nxt = S_TEN;
      S_TEN:   st_nxt = S_OUT;
      S_OUT:   if (res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic [31:0] half, hp2, tens_full;
  assign half = 32'(($signed(x_r) + (x_r[31] ? 33'sd1 : 33'sd0)) >>> 1);
  assign hp2  = half + 32'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    unique case (st_r)
      S_IDLE: begin
        ut_r <= q_item.ut; up_r <= q_item.up;
        res <= '0;
      end
      S_X1T:  a_r <= sra(prod, 5'd15);
      S_TDIV: begin
        neg_r <= mc[31] ^ den[31];
        if (den == 32'd0) res <= '{16'd0, 32'd0, 16'd0, 1'b1};
      end
      default: ;
    endcase
    if (st_r == S_TW && ddone) begin
      b5_r <= a_r + tq;
      res.temp <= 16'(sra(a_r + tq + 32'd8, 5'd4));
      e_r <= a_r + tq - 32'd4000;
    end
    if (st_r == S_B6) sq_r <= sra(prod, 5'd12);
    if (st_r == S_SQ) d_r <= sra(prod, 5'd11);
    if (st_r == S_M1) d_r <= d_r + sra(prod, 5'd11);
    if (st_r == S_M2) c_r <= sra(prod, 5'd13);
    if (st_r == S_M3) c_r <= sra(c_r + sra(prod, 5'd16) + 32'd2, 5'd2);
    if (st_r == S_M4) a_r <= sra(((ac1 * 32'd4 + d_r) << oss) + 32'd2, 5'd2);
    if (st_r == S_B3) b_r <= prod >> 15;
    if (st_r == S_B4) begin
      c_r <= prod;
      if (b_r == 32'd0) res <= '{16'd0, 32'd0, 16'd0, 1'b1};
    end
    if (st_r == S_PDIV) neg_r <= c_r[31];
    if (st_r == S_PW && ddone) x_r <= neg_r ? (dq << 1) : dq;
    if (st_r == S_P1) a_r <= prod;
    if (st_r == S_P2) a_r <= sra(prod, 5'd16);
    if (st_r == S_P3) d_r <= sra(32'd0 - prod, 5'd16);
    if (st_r == S_P4) x_r <= x_r + sra(a_r + d_r + 32'd3791, 5'd4);
    if (st_r == S_TEN) begin
      res.p <= x_r;
      res.tens <= tens_full[15:0];
    end
  end

  // (h+2)/5 truncating toward zero, via reciprocal multiply on magnitude
  logic [31:0] hmag, qd;
  logic [63:0] rp;
  assign hmag = hp2[31] ? (~hp2 + 32'd1) : hp2;
  assign rp   = {32'd0, hmag} * 64'hCCCCCCCD;
  assign qd   = {2'd0, rp[63:34]};
  assign tens_full = hp2[31] ? (~qd + 32'd1) : qd;
endmodule
`default_nettype wire

/* sv/baro_temp_pressure_compensation.sv */
// ---------------------------------------------------------------------------
// Barometric temperature/pressure compensation.
// in_ channel: one raw temperature and raw pressure reading per transfer.
// out_ channel: compensated temperature, pressure, rounded pressure, fault flag.
// cfg_ port: write enable, index and data for the calibration registers.
// A two-entry input queue decouples the front from the sequencer, so the
// block takes new readings while a result waits on the output.
// Each item takes two serial 32-bit divides and the steps of the shared
// multiplier. A zero divisor ends the item early.
// Items are processed one at a time in the back end.
// Reset (rst_n low, synchronous) loads calibration defaults and empties
// the queue. If the receiver stalls, the result holds and the queue fills.
// ---------------------------------------------------------------------------
`default_nettype none
module baro_temp_pressure_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // raw_temperature[15:0], raw_pressure[34:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // temperature[15:0], pressure_pa[47:16], tens[63:48]
  output logic             out_tuser,  // divide_fault
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import btpc_pkg::*;
  coef_t   coef_r;
  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= {RstAc12, RstAc34, RstAc56, RstB12, RstMcMd, 2'd0};
    end else if (cfg_we) begin
      unique case (32'(cfg_index))
        CfgAc12: coef_r.ac12 <= cfg_wdata;
        CfgAc34: coef_r.ac34 <= cfg_wdata;
        CfgAc56: coef_r.ac56 <= cfg_wdata;
        CfgB12:  coef_r.b12  <= cfg_wdata;
        CfgMcMd: coef_r.mcmd <= cfg_wdata;
        CfgOss:  coef_r.oss  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign in_item.ut = in_tdata[15:0];
  assign in_item.up = in_tdata[34:16];

  btpc_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
                      .in_item, .q_valid, .q_pop, .q_item);
  btpc_back u_back (.clk, .rst_n, .coef(coef_r), .q_valid, .q_pop, .q_item,
                    .res_valid(out_tvalid), .res_ready(out_tready), .res);

  assign out_tdata = {res.tens, res.p, res.temp};
  assign out_tuser = res.fault;

  `include "baro_temp_pressure_compensation_assert.svh"
  `BTPC_ASSERT_IMP(a_fault_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 64'd0)
  `BTPC_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
`default_nettype wire

/* test/tb_baro_temp_pressure_compensation.sv */
// ---------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation
// Drives raw temperature/pressure readings through the compensation block
// under several calibration settings, predicts each result in the
// scoreboard and compares it field by field with the block's output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_baro_temp_pressure_compensation;
  import btpc_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 200;

  class baro_scoreboard;
    coef_t   regs;
    result_t expected_q[$];
    int      errors;

    function new();
      regs = '{RstAc12, RstAc34, RstAc56, RstB12, RstMcMd, 2'd0};
      errors = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] val);
      case (idx)
        CfgAc12: regs.ac12 = val;
        CfgAc34: regs.ac34 = val;
        CfgAc56: regs.ac56 = val;
        CfgB12:  regs.b12 = val;
        CfgMcMd: regs.mcmd = val;
        CfgOss:  regs.oss = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] asr(logic [31:0] v, int s);
      return $signed(v) >>> s;
    endfunction

    function result_t compensate(item_t it);
      result_t r;
      logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
      int num, dv, ps, tens;
      r = '0;
      r.fault = 1'b1;
      ut  = {16'd0, it.ut};
      up  = {13'd0, it.up};
      ac1 = {{16{regs.ac12[31]}}, regs.ac12[31:16]};
      ac2 = {{16{regs.ac12[15]}}, regs.ac12[15:0]};
      ac3 = {{16{regs.ac34[31]}}, regs.ac34[31:16]};
      ac4 = {16'd0, regs.ac34[15:0]};
      ac5 = {16'd0, regs.ac56[31:16]};
      ac6 = {16'd0, regs.ac56[15:0]};
      b1  = {{16{regs.b12[31]}}, regs.b12[31:16]};
      b2  = {{16{regs.b12[15]}}, regs.b12[15:0]};
      mc  = {{16{regs.mcmd[31]}}, regs.mcmd[31:16]};
      md  = {{16{regs.mcmd[15]}}, regs.mcmd[15:0]};

      x1 = asr((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 32'd0) return r;
      num = mc << 11;
      dv = den;
      x2 = num / dv;
      b5 = x1 + x2;

      b6 = b5 - 32'd4000;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = asr(((ac1 * 32'd4 + x3) << regs.oss) + 32'd2, 2);
      x1 = asr(ac3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 32'd0) return r;

      b7 = (up - b3) * (32'd50000 >> regs.oss);
      if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      x1 = asr(p, 8) * asr(p, 8);
      x1 = asr(x1 * 32'd3038, 16);
      x2 = asr(32'd0 - 32'd7357 * p, 16);
      p = p + asr(x1 + x2 + 32'd3791, 4);
      ps = p;
      tens = (ps / 2 + 2) / 5;

      r.temp  = 16'(asr(b5 + 32'd8, 4));
      r.p     = p;
      r.tens  = 16'(tens);
      r.fault = 1'b0;
      return r;
    endfunction

    function void note_reading(item_t it);
      expected_q.push_back(compensate(it));
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.temp !== exp_r.temp) begin
        $display("%0t: temperature exp %h got %h", $time, exp_r.temp, got.temp);
        errors++;
      end
      if (got.p !== exp_r.p) begin
        $display("%0t: pressure_pa exp %h got %h", $time, exp_r.p, got.p);
        errors++;
      end
      if (got.tens !== exp_r.tens) begin
        $display("%0t: pressure_tens exp %h got %h", $time, exp_r.tens, got.tens);
        errors++;
      end
      if (got.fault !== exp_r.fault) begin
        $display("%0t: divide_fault exp %b got %b", $time, exp_r.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  baro_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int cycles;

  baro_temp_pressure_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[baro_temp_pressure_compensation] ERROR");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{out_tdata[15:0], out_tdata[47:16], out_tdata[63:48], out_tuser});
  end

  task automatic send_reading(logic [15:0] ut, logic [18:0] up);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, up, ut};
    do @(posedge clk); while (!in_tready);
    sb.note_reading('{ut, up});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(logic [31:0] a12, logic [31:0] a34, logic [31:0] a56,
                           logic [31:0] b12, logic [31:0] mm, logic [1:0] oss);
    write_reg(CfgAc12, a12);
    write_reg(CfgAc34, a34);
    write_reg(CfgAc56, a56);
    write_reg(CfgB12, b12);
    write_reg(CfgMcMd, mm);
    write_reg(CfgOss, {30'd0, oss});
  endtask

  // mostly plausible sensor readings, some anywhere in range
  task automatic send_random(int n);
    logic [15:0] ut;
    logic [18:0] up;
    repeat (n) begin
      if ($urandom_range(99) < 70) begin
        ut = 16'(24000 + $urandom_range(8000));
        up = 19'(($urandom_range(15000) + 18000) << sb.regs.oss);
      end else begin
        ut = 16'($urandom);
        up = 19'($urandom);
      end
      send_reading(ut, up);
    end
  endtask

  function automatic logic [31:0] tweak(logic [31:0] v);
    return v ^ {8'd0, 4'($urandom), 12'd0, 8'($urandom)};
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_cycles = 0;
    cycles = 0;
    send_idle_pct = 10;
    recv_idle_pct = 87;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes at reset calibration, oss 0 and 3
    send_reading(16'd27898, 19'd23843);
    send_reading(16'd0, 19'd0);
    send_reading(16'hFFFF, 19'h7FFFF);
    send_reading(16'd0, 19'h7FFFF);
    send_reading(16'hFFFF, 19'd0);
    send_reading(16'h8000, 19'h40000);
    send_reading(16'h7FFF, 19'h3FFFF);
    send_reading(16'h5555, 19'h2AAAA);
    send_reading(16'hAAAA, 19'h55555);
    wait_idle();
    write_reg(CfgOss, 32'd3);
    send_reading(16'd27898, 19'd23843 << 3);
    send_reading(16'd0, 19'h7FFFF);
    send_reading(16'hFFFF, 19'd0);
    send_reading(16'h1234, 19'h12345);
    // divisor x1+md zero: ac5 = 0 and md = 0
    wait_idle();
    write_reg(CfgAc56, 32'h0000_1234);
    write_reg(CfgMcMd, 32'hD8F0_0000);
    send_reading(16'd27898, 19'd23843);
    send_reading(16'hFFFF, 19'h7FFFF);
    // divisor b4 zero: ac4 = 0
    wait_idle();
    write_all(RstAc12, 32'hC7AA_0000, RstAc56, RstB12, RstMcMd, 2'd0);
    send_reading(16'd27898, 19'd23843);
    send_reading(16'd0, 19'd0);
    // out-of-range register indexes must be ignored
    wait_idle();
    write_reg(6, 32'hFFFF_FFFF);
    write_reg(7, 32'h0000_0000);
    send_reading(16'h4321, 19'h01234);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 10;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: write_all(RstAc12, RstAc34, RstAc56, RstB12, RstMcMd, 2'd3);
        1: write_all(tweak(RstAc12), tweak(RstAc34), tweak(RstAc56),
                     tweak(RstB12), tweak(RstMcMd), 2'd1);
        2: write_all($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
        3: write_all(RstAc12, RstAc34, {16'd0, 16'($urandom)}, RstB12,
                     {16'($urandom), 16'd0}, 2'd2);
        4: write_all(RstAc12, {16'($urandom), 16'd0}, RstAc56, RstB12, RstMcMd, 2'd0);
        5: write_all('1, '1, '1, '1, '1, 2'd3);
        6: write_all('0, '0, '0, '0, '0, 2'd0);
        7: write_all(RstAc12, RstAc34, RstAc56, RstB12, RstMcMd, 2'd0);
        default: write_all(tweak(RstAc12), tweak(RstAc34), tweak(RstAc56),
                           tweak(RstB12), tweak(RstMcMd), 2'($urandom));
      endcase
      // long receiver hold-off so the input queue fills and stalls
      if (ph == 7) hold_cycles = 400;
      send_random((ph == 3 || ph == 4 || ph == 6) ? 40 : 130);
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[baro_temp_pressure_compensation] OK");
    end else begin
      $display("[baro_temp_pressure_compensation] ERROR");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/btpc_pkg.sv
sv/btpc_div.sv
sv/btpc_front.sv
sv/btpc_back.sv
sv/baro_temp_pressure_compensation.sv
test/tb_baro_temp_pressure_compensation.sv
